>>> hw/rtl/kcl_pkg.sv
package kcl_pkg;

  localparam int unsigned COORD_W     = 20;
  localparam int unsigned SCALE_W     = 20;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned LEN_W       = 40;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned MAG_W       = 20;
  localparam int unsigned PROD_W      = 40;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned Q_W         = 25;
  localparam int unsigned SQ_W        = 50;
  localparam int unsigned SUM_W       = 52;
  localparam int unsigned ROOT_W      = 26;
  localparam int unsigned LANE_CNT_W  = $clog2(Q_W);
  localparam int unsigned SQRT_CNT_W  = $clog2(ROOT_W);
  localparam int unsigned NUM_LANES   = 3;

  localparam int unsigned STEPS_DEFAULT = 10;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(411775);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(66);
  localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_A   = 2'd0,
    REG_SCALE_B   = 2'd1,
    REG_SCALE_C   = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_PREP,
    L_DIV,
    L_SQLD,
    L_SQR,
    L_DONE
  } lane_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LANE,
    S_SQRT,
    S_ROUND,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic            done;
    logic            hit;
    logic [SQ_W-1:0] square;
  } lane_res_t;

endpackage

>>> hw/rtl/kpath_cumulative_length.sv
// an accepted request runs the bit-serial multiply, divide and square in each
// axis lane, then the bit-serial square root (two radicand bits per step),
// then emits its results, one per cycle while out_stall_i is low
// a new segment is taken only when idle; one with no counted axis emits nothing
// reset: asynchronous active low, clears the running length and loads register defaults
module kpath_cumulative_length
  import kcl_pkg::*;
#(
  parameter int unsigned STEPS_PER_SEGMENT = STEPS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_W-1:0]    start_x_i,
  input  logic [COORD_W-1:0]    start_y_i,
  input  logic [COORD_W-1:0]    start_z_i,
  input  logic [COORD_W-1:0]    end_x_i,
  input  logic [COORD_W-1:0]    end_y_i,
  input  logic [COORD_W-1:0]    end_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEN_W-1:0]      path_length_o,
  output logic                  last_of_segment_o
);

  localparam int unsigned K_W = $clog2(STEPS_PER_SEGMENT + 1);

  state_e                state_q, state_d;
  logic [SCALE_W-1:0]    scale_a_q, scale_b_q, scale_c_q;
  logic [THR_W-1:0]      thr_q;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [SUM_W-1:0]      rad_q, rad_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_W:0]       rem_q, rem_d;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic [K_W-1:0]        k_q, k_d;
  logic                  out_valid_q, out_valid_d;
  logic [LEN_W-1:0]      out_len_q, out_len_d;
  logic                  out_last_q, out_last_d;

  lane_res_t             lane_res [NUM_LANES];
  logic                  in_accept;
  logic                  any_hit;
  logic [SUM_W-1:0]      sq_sum;
  logic [ROOT_W+2:0]     sq_sh;
  logic [ROOT_W+2:0]     sq_trial;
  logic                  sq_ge;
  logic [LEN_W:0]        len_sum;
  logic                  out_load;
  logic                  k_last;
  cfg_reg_e              cfg_reg;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign cfg_reg = cfg_reg_e'(cfg_index_i);

  kcl_axis #(.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)) u_lane_x (
    .clk_i, .rst_ni, .start_i(in_accept),
    .start_coord_i(start_x_i), .end_coord_i(end_x_i),
    .scale_i(scale_a_q), .threshold_i(thr_q), .res_o(lane_res[0])
  );

  kcl_axis #(.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)) u_lane_y (
    .clk_i, .rst_ni, .start_i(in_accept),
    .start_coord_i(start_y_i), .end_coord_i(end_y_i),
    .scale_i(scale_b_q), .threshold_i(thr_q), .res_o(lane_res[1])
  );

  kcl_axis #(.STEPS_PER_SEGMENT(STEPS_PER_SEGMENT)) u_lane_z (
    .clk_i, .rst_ni, .start_i(in_accept),
    .start_coord_i(start_z_i), .end_coord_i(end_z_i),
    .scale_i(scale_c_q), .threshold_i(thr_q), .res_o(lane_res[2])
  );

  assign any_hit  = lane_res[0].hit || lane_res[1].hit || lane_res[2].hit;
  assign sq_sum   = SUM_W'(lane_res[0].square) + SUM_W'(lane_res[1].square)
                  + SUM_W'(lane_res[2].square);
  assign sq_sh    = {rem_q, rad_q[SUM_W-1 -: 2]};
  assign sq_trial = (ROOT_W + 3)'({root_q, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;
  assign len_sum  = {1'b0, len_q} + (LEN_W + 1)'(root_q);
  assign out_load = !out_valid_q || !out_stall_i;
  assign k_last   = k_q == K_W'(STEPS_PER_SEGMENT - 1);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rad_d       = rad_q;
    root_d      = root_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_LANE;
        end
      end
      S_LANE: begin
        if (lane_res[0].done) begin
          rad_d  = sq_sum;
          root_d = '0;
          rem_d  = '0;
          cnt_d  = '0;
          state_d = any_hit ? S_SQRT : S_IDLE;
        end
      end
      S_SQRT: begin
        rem_d  = sq_ge ? (ROOT_W + 1)'(sq_sh - sq_trial) : sq_sh[ROOT_W:0];
        root_d = {root_q[ROOT_W-2:0], sq_ge};
        rad_d  = {rad_q[SUM_W-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == SQRT_CNT_W'(ROOT_W - 1)) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rem_q > (ROOT_W + 1)'(root_q)) begin
          root_d = root_q + 1'b1;
        end
        k_d     = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          len_d       = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
          out_len_d   = len_d;
          out_last_d  = k_last;
          out_valid_d = 1'b1;
          k_d         = k_q + 1'b1;
          if (k_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      scale_a_q   <= SCALE_RESET;
      scale_b_q   <= SCALE_RESET;
      scale_c_q   <= SCALE_RESET;
      thr_q       <= THR_RESET;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg)
          REG_SCALE_A:   scale_a_q <= cfg_data_i[SCALE_W-1:0];
          REG_SCALE_B:   scale_b_q <= cfg_data_i[SCALE_W-1:0];
          REG_SCALE_C:   scale_c_q <= cfg_data_i[SCALE_W-1:0];
          REG_THRESHOLD: thr_q     <= cfg_data_i[THR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q      <= rad_d;
    root_q     <= root_d;
    rem_q      <= rem_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign path_length_o     = out_len_q;
  assign last_of_segment_o = out_last_q;

`ifndef SYNTH
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_res[0].done == lane_res[1].done && lane_res[0].done == lane_res[2].done)
    else $error("axis lanes out of step");

  a_len_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && out_load |=> len_q >= $past(len_q))
    else $error("running length decreased");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_EMIT)
    else $error("result raised outside emission");

  a_sqrt_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> rem_q <= {root_q, 1'b0})
    else $error("square root remainder too large");
`endif

endmodule

>>> hw/rtl/kcl_axis.sv
module kcl_axis
  import kcl_pkg::*;
#(
  parameter int unsigned STEPS_PER_SEGMENT = STEPS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] start_coord_i,
  input  logic [COORD_W-1:0] end_coord_i,
  input  logic [SCALE_W-1:0] scale_i,
  input  logic [THR_W-1:0]   threshold_i,
  output lane_res_t          res_o
);

  localparam int unsigned REM_W = $clog2(STEPS_PER_SEGMENT + 1);
  localparam longint unsigned ROUND_ADD = longint'(STEPS_PER_SEGMENT) << (FRAC_W - 1);

  lane_state_e           state_q, state_d;
  logic [LANE_CNT_W-1:0] cnt_q, cnt_d;
  logic                  hit_q, hit_d;
  logic [SQ_W-1:0]       acc_q, acc_d;
  logic [SQ_W-1:0]       mcand_q, mcand_d;
  logic [Q_W-1:0]        mplier_q, mplier_d;
  logic [Q_W-1:0]        dvd_q, dvd_d;
  logic [REM_W-1:0]      rem_q, rem_d;

  logic [COORD_W:0]      diff;
  logic [COORD_W:0]      mag_full;
  logic [MAG_W-1:0]      mag;
  logic [PROD_W:0]       rounded;
  logic [REM_W:0]        div_sh;
  logic                  div_ge;
  logic [Q_W-1:0]        comp;

  assign diff     = {end_coord_i[COORD_W-1], end_coord_i}
                  - {start_coord_i[COORD_W-1], start_coord_i};
  assign mag_full = diff[COORD_W] ? (~diff + 1'b1) : diff;
  assign mag      = mag_full[MAG_W-1:0];
  assign rounded  = {1'b0, acc_q[PROD_W-1:0]} + (PROD_W + 1)'(ROUND_ADD);
  assign div_sh   = {rem_q, dvd_q[Q_W-1]};
  assign div_ge   = div_sh >= (REM_W + 1)'(STEPS_PER_SEGMENT);
  assign comp     = hit_q ? dvd_q : '0;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          hit_d    = mag > MAG_W'(threshold_i);
          mcand_d  = SQ_W'(scale_i);
          mplier_d = Q_W'(mag);
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = L_MUL;
        end
      end
      L_MUL, L_SQR: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[SQ_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[Q_W-1:1]};
        cnt_d    = cnt_q + 1'b1;
        if (state_q == L_MUL && cnt_q == LANE_CNT_W'(MAG_W - 1)) begin
          state_d = L_PREP;
        end else if (state_q == L_SQR && cnt_q == LANE_CNT_W'(Q_W - 1)) begin
          state_d = L_DONE;
        end
      end
      L_PREP: begin
        dvd_d   = rounded[FRAC_W +: Q_W];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = L_DIV;
      end
      L_DIV: begin
        rem_d = div_ge ? REM_W'(div_sh - (REM_W + 1)'(STEPS_PER_SEGMENT))
                       : div_sh[REM_W-1:0];
        dvd_d = {dvd_q[Q_W-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LANE_CNT_W'(Q_W - 1)) begin
          state_d = L_SQLD;
        end
      end
      L_SQLD: begin
        mcand_d  = SQ_W'(comp);
        mplier_d = comp;
        acc_d    = '0;
        cnt_d    = '0;
        state_d  = L_SQR;
      end
      L_DONE: begin
        state_d = L_IDLE;
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
  end

  assign res_o.done   = state_q == L_DONE;
  assign res_o.hit    = hit_q;
  assign res_o.square = acc_q;

`ifndef SYNTH
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == L_DIV |-> rem_q < REM_W'(STEPS_PER_SEGMENT))
    else $error("division remainder out of range");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == L_DONE && !hit_q |-> acc_q == '0)
    else $error("uncounted axis gave nonzero square");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == L_IDLE && start_i |=> state_q == L_MUL && cnt_q == '0)
    else $error("lane did not start");
`endif

endmodule

>>> bench/kpath_cumulative_length_tb.sv
module kpath_cumulative_length_tb
  import kcl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS = STEPS_DEFAULT;
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [CFG_DATA_W-1:0] DATA_ALL = {CFG_DATA_W{1'b1}};
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 50;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] start_z;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] end_z;
  } segment_t;

  class arc_length_tracker;
    logic [SCALE_W-1:0] scale_a;
    logic [SCALE_W-1:0] scale_b;
    logic [SCALE_W-1:0] scale_c;
    logic [THR_W-1:0]   threshold;
    logic [LEN_W-1:0]   running;
    logic [LEN_W:0]     expected_lengths[$];
    int unsigned        errors;

    function new();
      scale_a   = SCALE_RESET;
      scale_b   = SCALE_RESET;
      scale_c   = SCALE_RESET;
      threshold = THR_RESET;
      running   = '0;
      errors    = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCALE_A:   scale_a = data[SCALE_W-1:0];
        REG_SCALE_B:   scale_b = data[SCALE_W-1:0];
        REG_SCALE_C:   scale_c = data[SCALE_W-1:0];
        REG_THRESHOLD: threshold = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned axis_step(input logic [COORD_W-1:0] s,
                                        input logic [COORD_W-1:0] e,
                                        input logic [SCALE_W-1:0] k,
                                        output bit hit);
      longint signed d;
      longint unsigned mag;
      longint unsigned den;
      d = longint'($signed(e)) - longint'($signed(s));
      mag = (d < 0) ? longint'(-d) : longint'(d);
      den = longint'(STEPS) << FRAC_W;
      hit = (mag > longint'(threshold));
      if (!hit) return 0;
      return (mag * longint'(k) + (den >> 1)) / den;
    endfunction

    function longint unsigned square_root(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    function void note_segment(segment_t seg);
      bit hx, hy, hz;
      longint unsigned cx, cy, cz, sum, root;
      cx = axis_step(seg.start_x, seg.end_x, scale_a, hx);
      cy = axis_step(seg.start_y, seg.end_y, scale_b, hy);
      cz = axis_step(seg.start_z, seg.end_z, scale_c, hz);
      if (!hx && !hy && !hz) return;
      sum = cx * cx + cy * cy + cz * cz;
      root = square_root(sum);
      if (sum - root * root > root) root++;
      for (int unsigned k = 0; k < STEPS; k++) begin
        if (root >= longint'(LEN_MAX - running)) running = LEN_MAX;
        else running = running + LEN_W'(root);
        expected_lengths.insert(expected_lengths.size(), {k == STEPS - 1, running});
      end
    endfunction

    function int unsigned pending();
      return expected_lengths.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_length(logic [LEN_W-1:0] got_len, logic got_last);
      logic [LEN_W:0] want;
      if (expected_lengths.size() == 0) begin
        report_mismatch($sformatf("unexpected result length %0d last %0b", got_len, got_last));
        return;
      end
      want = expected_lengths.pop_front();
      if (got_len !== want[LEN_W-1:0])
        report_mismatch($sformatf("length %0d, want %0d", got_len, want[LEN_W-1:0]));
      if (got_last !== want[LEN_W])
        report_mismatch($sformatf("last flag %0b, want %0b", got_last, want[LEN_W]));
    endtask

    task flag_leftovers();
      if (expected_lengths.size() != 0)
        report_mismatch($sformatf("%0d results never came", expected_lengths.size()));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [COORD_W-1:0]    start_x_i;
  logic [COORD_W-1:0]    start_y_i;
  logic [COORD_W-1:0]    start_z_i;
  logic [COORD_W-1:0]    end_x_i;
  logic [COORD_W-1:0]    end_y_i;
  logic [COORD_W-1:0]    end_z_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [LEN_W-1:0]      path_length_o;
  logic                  last_of_segment_o;

  arc_length_tracker tracker;
  bit calm;
  bit want_hold;

  kpath_cumulative_length dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .start_z_i         (start_z_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .end_z_i           (end_z_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .path_length_o     (path_length_o),
    .last_of_segment_o (last_of_segment_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: checks each result, random stall unless calm, plus one long hold-off when asked
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) tracker.check_length(path_length_o, last_of_segment_o);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 30);
      end
    end
  end

  task automatic send_segment(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input logic [COORD_W-1:0] sz, input logic [COORD_W-1:0] ex,
                              input logic [COORD_W-1:0] ey, input logic [COORD_W-1:0] ez);
    segment_t seg;
    seg = {sx, sy, sz, ex, ey, ez};
    while (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    start_z_i  <= sz;
    end_x_i    <= ex;
    end_y_i    <= ey;
    end_z_i    <= ez;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_segment(seg);
  endtask

  task automatic pick_axis(output logic [COORD_W-1:0] s, output logic [COORD_W-1:0] e);
    int unsigned mode;
    int unsigned span;
    mode = $urandom_range(9);
    span = int'(tracker.threshold) + 1;
    s = COORD_W'($urandom);
    if (mode < 5) e = COORD_W'($urandom);
    else if (mode < 8) e = s + COORD_W'($urandom_range(2 * span)) - COORD_W'(span);
    else e = s;
  endtask

  task automatic send_random_segment();
    logic [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
    pick_axis(sx, ex);
    pick_axis(sy, ey);
    pick_axis(sz, ez);
    send_segment(sx, sy, sz, ex, ey, ez);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, data);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] sa, logic [CFG_DATA_W-1:0] sb,
                           logic [CFG_DATA_W-1:0] sc, logic [CFG_DATA_W-1:0] thr);
    wait_for_drain();
    write_register(REG_SCALE_A, sa);
    write_register(REG_SCALE_B, sb);
    write_register(REG_SCALE_C, sc);
    write_register(REG_THRESHOLD, thr);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] thr;
    tracker     = new();
    calm        = 1'b0;
    want_hold   = 1'b0;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_SCALE_A;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    start_x_i   <= '0;
    start_y_i   <= '0;
    start_z_i   <= '0;
    end_x_i     <= '0;
    end_y_i     <= '0;
    end_z_i     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: threshold edge, single axes, direction, extremes
    send_segment('0, '0, '0, '0, '0, '0);
    send_segment('0, '0, '0, 20'd66, '0, '0);
    send_segment('0, '0, '0, 20'd67, '0, '0);
    send_segment('0, 20'd67, '0, '0, '0, '0);
    send_segment('0, '0, 20'd1000, '0, '0, 20'd101000);
    send_segment(COORD_MIN, '0, '0, COORD_MAX, '0, '0);
    send_segment(COORD_MAX, '0, '0, COORD_MIN, '0, '0);
    send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    send_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    send_segment(COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0);
    send_segment(20'd5, 20'd5, COORD_MIN, 20'd60, 20'd10, '0);
    send_segment(20'd1, 20'd2, 20'd3, 20'd2, 20'd3, 20'd4);

    // widest scales, zero threshold
    configure(DATA_ALL, DATA_ALL, DATA_ALL, '0);
    send_segment('0, '0, '0, 20'd1, '0, '0);
    send_segment(20'd9, 20'd9, 20'd9, 20'd9, 20'd9, 20'd9);
    send_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);

    // zero scales, threshold data with bits above the register width
    configure('0, '0, '0, DATA_ALL);
    send_segment('0, '0, '0, 20'd65535, '0, '0);
    send_segment('0, '0, '0, '0, 20'd65536, '0);
    send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 2 == 1) thr = CFG_DATA_W'($urandom_range(0, 4000));
      else thr = CFG_DATA_W'($urandom);
      configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), thr);
      calm = (p == 2);
      if (p == 1) want_hold = 1'b1;
      repeat (PHASE_ITEMS) send_random_segment();
    end
    calm = 1'b0;

    wait_for_drain();
    tracker.flag_leftovers();
    if (tracker.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
